/* sv/sgm_pkg.sv */
`default_nettype none
package sgm_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int ColW = $clog2(MaxWidth);
    localparam int DimW = 11;
    localparam int RowW = 11;
    localparam int SumW = 17;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQRT,
        ST_OUT
    } state_t;

    function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
        logic [DimW-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = {{(DimW-1){1'b0}}, 1'b1};
            else if (v > maxv)
                r = maxv;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* sv/sobel_gradient_magnitude.sv */
// Path: an accepted word that yields a result passes the memory read and kernel sum
// stage, then 8 root iterations, before its result word is registered.
// Flow: a word that yields a result holds off the next input through the root unit, output
// handoff and return to idle; one that yields none holds it off only during its memory read
// stage; a waiting result holds the input.
// Reset: counters, window and handshake state clear; line memory is not cleared
// (entries are read only after being written in the same frame).
`default_nettype none
module sobel_gradient_magnitude import sgm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // pixel_value[7:0]
    input  wire logic        s_tuser,   // drain
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // edge_strength[7:0], out_col[17:8], out_row[27:18] pad
    output logic             m_tlast,   // frame_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    localparam logic [DimW-1:0] MaxW = DimW'(MaxWidth);
    localparam logic [DimW-1:0] MaxH = DimW'(MaxHeight);

    logic [7:0] mem_prev [MaxWidth];
    logic [7:0] mem_prev2 [MaxWidth];

    logic [DimW-1:0] width_reg, height_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [7:0] win_reg [9];
    state_t state_reg, state_next;
    logic [3:0] step_reg;
    logic rd_pend_reg;
    logic [7:0] x_reg;
    logic final_reg, emit_reg;
    logic [9:0] ocol_reg, orow_reg;
    logic olast_reg;
    logic [SumW-1:0] sum_reg;
    logic sat_reg;
    logic [7:0] root_reg;
    logic [ColW-1:0] rcol_reg;
    logic c0_reg;
    logic [7:0] rd_top, rd_mid;
    logic [7:0] out_e_reg;
    logic [9:0] out_c_reg, out_r_reg;
    logic out_l_reg, out_v_reg;

    logic [DimW-1:0] w, h;
    logic [ColW-1:0] c;
    logic pix_phase, acc;
    assign w = eff_dim(width_reg, MaxW);
    assign h = eff_dim(height_reg, MaxH);
    assign c = ({1'b0, col_reg} >= w) ? ColW'(w - 1'b1) : col_reg;
    assign pix_phase = row_reg < RowW'(h);
    assign s_tready = (state_reg == ST_IDLE) && !rd_pend_reg && !out_v_reg;
    assign acc = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == ST_IDLE) && !rd_pend_reg;

    // memory read and write-back stage
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_top <= mem_prev2[c];
            rd_mid <= mem_prev[c];
        end
        if (rd_pend_reg && !final_reg)
        begin
            mem_prev2[rcol_reg] <= rd_mid;
            mem_prev[rcol_reg]  <= x_reg;
        end
    end

    // window and gradient
    logic [7:0] top, mid, nwin [9];
    logic signed [11:0] gx, gy;
    logic [10:0] ax, ay;
    always_comb
    begin
        top = (row_reg >= RowW'(2)) ? rd_top : 8'd0;
        mid = (row_reg >= RowW'(1)) ? rd_mid : 8'd0;
        for (int i = 0; i < 6; i++)
            nwin[i] = win_reg[i+3];
        // first column of a row or final drain word: the finished row's last result sees zero padding
        nwin[6] = (final_reg || c0_reg) ? 8'd0 : top;
        nwin[7] = (final_reg || c0_reg) ? 8'd0 : mid;
        nwin[8] = (final_reg || c0_reg) ? 8'd0 : x_reg;
        gx = (12'(nwin[6]) + {3'd0, nwin[7], 1'b0} + 12'(nwin[8]))
           - (12'(nwin[0]) + {3'd0, nwin[1], 1'b0} + 12'(nwin[2]));
        gy = (12'(nwin[2]) + {3'd0, nwin[5], 1'b0} + 12'(nwin[8]))
           - (12'(nwin[0]) + {3'd0, nwin[3], 1'b0} + 12'(nwin[6]));
        ax = gx[11] ? 11'(-gx) : 11'(gx);
        ay = gy[11] ? 11'(-gy) : 11'(gy);
    end

    logic [21:0] sq_sum;
    assign sq_sum = {11'd0, ax} * {11'd0, ax} + {11'd0, ay} * {11'd0, ay};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (rd_pend_reg && emit_reg) state_next = ST_SQRT;
            ST_SQRT: if (step_reg == 4'd0) state_next = ST_OUT;
            ST_OUT:  if (!out_v_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [7:0] trial;
    logic [15:0] tsq;
    assign trial = root_reg | (8'd1 << step_reg[2:0]);
    assign tsq = trial * trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            width_reg <= MaxW;
            height_reg <= MaxH;
            col_reg <= '0;
            row_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_v_reg <= 1'b0;
            step_reg <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_v_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WIDTH) width_reg <= cfg_data;
                else height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
            end
            rd_pend_reg <= 1'b0;
            if (acc && (pix_phase != s_tuser))
            begin
                rd_pend_reg <= 1'b1;
                x_reg <= pix_phase ? s_tdata : 8'd0;
                rcol_reg <= c;
                c0_reg <= (c == '0);
                final_reg <= row_reg >= RowW'(h + 1'b1);
                if (row_reg >= RowW'(h + 1'b1))
                begin
                    emit_reg <= 1'b1;
                    ocol_reg <= 10'(w - 1'b1);
                    orow_reg <= 10'(h - 1'b1);
                    olast_reg <= 1'b1;
                end
                else if (c == '0)
                begin
                    emit_reg <= row_reg >= RowW'(2);
                    ocol_reg <= 10'(w - 1'b1);
                    orow_reg <= 10'(row_reg - RowW'(2));
                    olast_reg <= 1'b0;
                end
                else
                begin
                    emit_reg <= row_reg >= RowW'(1);
                    ocol_reg <= 10'(c - 1'b1);
                    orow_reg <= 10'(row_reg - RowW'(1));
                    olast_reg <= 1'b0;
                end
            end
            if (rd_pend_reg)
            begin
                sum_reg <= sq_sum[SumW-1:0];
                sat_reg <= |sq_sum[21:16];
                root_reg <= 8'd0;
                step_reg <= 4'd7;
                if (final_reg)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
                end
                else
                begin
                    if (c0_reg)
                    begin
                        for (int i = 0; i < 6; i++) win_reg[i] <= 8'd0;
                        win_reg[6] <= top;
                        win_reg[7] <= mid;
                        win_reg[8] <= x_reg;
                    end
                    else
                    begin
                        for (int i = 0; i < 9; i++) win_reg[i] <= nwin[i];
                    end
                    if ({1'b0, rcol_reg} + 1'b1 >= w)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                        col_reg <= rcol_reg + 1'b1;
                end
            end
            if (state_reg == ST_SQRT)
            begin
                if ({1'b0, tsq} <= sum_reg) root_reg <= trial;
                if (step_reg != 4'd0) step_reg <= step_reg - 1'b1;
                else
                begin
                    out_v_reg <= 1'b1;
                    out_e_reg <= sat_reg ? 8'd255
                               : (({1'b0, tsq} <= sum_reg) ? trial : root_reg);
                    out_c_reg <= ocol_reg;
                    out_r_reg <= orow_reg;
                    out_l_reg <= olast_reg;
                end
            end
        end
    end

    always_comb
    begin
        m_tvalid = out_v_reg;
        m_tdata = {4'd0, out_r_reg, out_c_reg, out_e_reg};
        m_tlast = out_l_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (pix_phase != s_tuser)) |=> !s_tready)
        else $error("accept while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> !s_tready)
        else $error("ready during root");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (state_reg == ST_OUT || state_reg == ST_IDLE))
        else $error("result outside output state");
endmodule
`default_nettype wire
